### design/hros_pkg.sv
// Shared constants, codes and cell control type for the heart-rate smoother.
`default_nettype none
package hros_pkg;
	localparam int WINDOW   = 10;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = 16 + CNT_W;
	localparam int V_W      = 22;
	localparam int STEP_MAX = (SUM_W > WINDOW) ? SUM_W : WINDOW;
	localparam int STEP_W   = $clog2(STEP_MAX + 1);
	localparam int KEY_W    = 17;

	localparam logic [1:0] ST_ACCEPT  = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_OUTLIER = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	localparam logic [2:0] REG_FILTER_MODE = 3'd0;
	localparam logic [2:0] REG_INT8        = 3'd1;
	localparam logic [2:0] REG_SCALE       = 3'd2;
	localparam logic [2:0] REG_ZERO_POINT  = 3'd3;
	localparam logic [2:0] REG_LOW_LIMIT   = 3'd4;
	localparam logic [2:0] REG_HIGH_LIMIT  = 3'd5;
	localparam logic [2:0] REG_OUT_LIMIT   = 3'd6;
	localparam logic [2:0] REG_FALLBACK    = 3'd7;

	typedef struct packed {
		logic shift_hist;
		logic load_key;
		logic sort_step;
		logic phase;
		logic shift_key;
	} cell_ctl_t;
endpackage
`default_nettype wire

### design/hros_cell.sv
// One history cell: a stored entry plus a sort key for the odd-even sort.
`default_nettype none
module hros_cell (
	input  wire logic                      clk,
	input  wire hros_pkg::cell_ctl_t       ctl,
	input  wire logic                      pos_odd,
	input  wire logic                      in_window,
	input  wire logic [15:0]               left_hist,
	input  wire logic [hros_pkg::KEY_W-1:0] left_key,
	input  wire logic [hros_pkg::KEY_W-1:0] right_key,
	output logic      [15:0]               hist,
	output logic      [hros_pkg::KEY_W-1:0] key
);
	import hros_pkg::*;

	logic [15:0]      hist_q;
	logic [KEY_W-1:0] key_q;
	logic             low_side;

	// low side of a pair keeps the minimum, high side the maximum
	assign low_side = (pos_odd == ctl.phase);

	always_ff @(posedge clk) begin
		if (ctl.shift_hist) begin
			hist_q <= left_hist;
		end
		if (ctl.load_key) begin
			key_q <= {~in_window, hist_q};
		end else if (ctl.sort_step) begin
			if (low_side) begin
				key_q <= (right_key < key_q) ? right_key : key_q;
			end else begin
				key_q <= (left_key > key_q) ? left_key : key_q;
			end
		end else if (ctl.shift_key) begin
			key_q <= right_key;
		end
	end

	assign hist = hist_q;
	assign key  = key_q;
endmodule
`default_nettype wire

### design/heart_rate_outlier_median_smoother.sv
// Top level: heart-rate smoother with range check, outlier rejection and mean/median filter.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | cmd, raw_value, value_bad
//  out     | out_valid / out_stall| heart_rate, status
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One word at a time. A clear word goes from S_IDLE straight to S_DONE and an
// invalid word passes S_CHK first. Stored or outlier words go on through S_PREP
// to S_DIV (mean, bit-serial divider) or to S_SORT and S_SHIFT (median, odd-even
// sort along the cell row); a stalled output holds the word in S_DONE.
// arst_n clears control and configuration; entries need no clearing.
// in_stall is high while a word is in work; a finished result waits in the
// output register while the next word is taken in.
`default_nettype none
module heart_rate_outlier_median_smoother (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [15:0] raw_value,
	input  wire logic        value_bad,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [15:0] heart_rate,
	output logic      [1:0]  status,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import hros_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHK, S_PREP, S_SORT, S_SHIFT, S_DIV, S_DONE} state_t;

	// configuration
	logic              mode_q, int8_q;
	logic [15:0]       scale_q, low_q, high_q, olim_q, fall_q;
	logic signed [7:0] zp_q;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [15:0]       res_q;
	logic [1:0]        rst_q;
	logic signed [V_W-1:0] v_s1;
	logic              bad_s1;
	logic [15:0]       hr_q;
	logic [1:0]        st_q;
	logic              ov_q;

	// cell row
	cell_ctl_t         ctl;
	logic [15:0]       hist [WINDOW];
	logic [KEY_W-1:0]  key  [WINDOW];

	// per-word arithmetic
	logic signed [8:0]     d;
	logic signed [25:0]    p;
	logic signed [V_W-1:0] v_in;
	logic [15:0]           x;
	logic                  invalid, outlier;
	logic [SUM_W-1:0]      xn, limn, dropped;
	logic signed [SUM_W:0] dev;
	logic [SUM_W-1:0]      dev_abs;
	logic [CNT_W:0]        trial;
	logic                  ge;
	logic [KEY_W:0]        pair_sum;
	logic                  store;

	assign d    = $signed({raw_value[7], raw_value[7:0]}) - $signed({zp_q[7], zp_q});
	assign p    = d * $signed({1'b0, scale_q});
	assign v_in = int8_q ? V_W'(p >>> 4) : V_W'(signed'(raw_value));

	assign x       = v_s1[15:0];
	assign invalid = bad_s1 || (v_s1 < $signed({{(V_W-16){1'b0}}, low_q}))
		|| (v_s1 > $signed({{(V_W-16){1'b0}}, high_q}));
	assign xn      = SUM_W'(x * count_q);
	assign limn    = SUM_W'(olim_q * count_q);
	assign dev     = $signed({1'b0, xn}) - $signed({1'b0, sum_q});
	assign dev_abs = dev[SUM_W] ? SUM_W'(-dev) : dev[SUM_W-1:0];
	assign outlier = (count_q != '0) && (dev_abs > limn);
	assign store   = (state_q == S_CHK) && !invalid && !outlier;
	assign dropped = (count_q == CNT_W'(WINDOW)) ? SUM_W'(hist[WINDOW-1]) : '0;

	// restoring divide, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, count_q};

	assign pair_sum = {1'b0, key[0]} + {1'b0, key[1]};

	always_comb begin
		ctl            = '0;
		ctl.shift_hist = store;
		ctl.load_key   = (state_q == S_PREP) && mode_q;
		ctl.sort_step  = (state_q == S_SORT);
		ctl.phase      = step_q[0];
		ctl.shift_key  = (state_q == S_SHIFT) && (step_q != '0);
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		hros_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos_odd   (1'(i % 2)),
			.in_window (CNT_W'(i) < count_q),
			.left_hist ((i == 0) ? x : hist[(i == 0) ? 0 : i-1]),
			.left_key  ((i == 0) ? KEY_W'(0) : key[(i == 0) ? 0 : i-1]),
			.right_key ((i == WINDOW-1) ? {1'b1, 16'h0} : key[(i == WINDOW-1) ? i : i+1]),
			.hist      (hist[i]),
			.key       (key[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			int8_q  <= 1'b0;
			scale_q <= 16'd4819;
			zp_q    <= '0;
			low_q   <= 16'd7680;
			high_q  <= 16'd46080;
			olim_q  <= 16'd5120;
			fall_q  <= 16'd19200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_MODE: mode_q  <= cfg_data[0];
				REG_INT8:        int8_q  <= cfg_data[0];
				REG_SCALE:       scale_q <= cfg_data;
				REG_ZERO_POINT:  zp_q    <= cfg_data[7:0];
				REG_LOW_LIMIT:   low_q   <= cfg_data;
				REG_HIGH_LIMIT:  high_q  <= cfg_data;
				REG_OUT_LIMIT:   olim_q  <= cfg_data;
				REG_FALLBACK:    fall_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			v_s1   <= v_in;
			bad_s1 <= value_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sum_q   <= '0;
			step_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			res_q   <= '0;
			rst_q   <= ST_ACCEPT;
			hr_q    <= '0;
			st_q    <= ST_ACCEPT;
			ov_q    <= 1'b0;
		end else begin
			// output register: loaded from S_DONE, emptied when taken
			if (state_q == S_DONE && (!ov_q || !out_stall)) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd) begin
							count_q <= '0;
							sum_q   <= '0;
							res_q   <= fall_q;
							rst_q   <= ST_CLEARED;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (invalid) begin
						res_q   <= (count_q != '0) ? hist[0] : fall_q;
						rst_q   <= ST_INVALID;
						state_q <= S_DONE;
					end else begin
						if (outlier) begin
							rst_q <= ST_OUTLIER;
						end else begin
							rst_q <= ST_ACCEPT;
							sum_q <= sum_q + SUM_W'(x) - dropped;
							if (count_q != CNT_W'(WINDOW)) begin
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (mode_q) begin
						step_q  <= STEP_W'(WINDOW);
						state_q <= S_SORT;
					end else begin
						quo_q   <= sum_q;
						rem_q   <= '0;
						step_q  <= STEP_W'(SUM_W);
						state_q <= S_DIV;
					end
				end
				S_SORT: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						step_q  <= STEP_W'((count_q - 1'b1) >> 1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (step_q == '0) begin
						res_q   <= count_q[0] ? key[0][15:0] : pair_sum[16:1];
						state_q <= S_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_DIV: begin
					rem_q  <= ge ? CNT_W'(trial - {1'b0, count_q}) : CNT_W'(trial);
					quo_q  <= {quo_q[SUM_W-2:0], ge};
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ov_q || !out_stall) begin
						hr_q    <= (rst_q == ST_CLEARED || rst_q == ST_INVALID || mode_q)
							? res_q : quo_q[15:0];
						st_q    <= rst_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = ov_q;
	assign heart_rate = hr_q;
	assign status     = st_q;

`ifndef NO_ASSERTIONS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW)) else $error("history count beyond window");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd) |=> (count_q == '0 && sum_q == '0))
		else $error("clear did not empty history");
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0)) else $error("sum left over with no entries");
`endif
endmodule
`default_nettype wire

### tb/heart_rate_outlier_median_smoother_tb.sv
// Self-checking testbench for the heart-rate smoother: directed table, int8 extremes, then random words.
`timescale 1ns / 100ps
`default_nettype none
module heart_rate_outlier_median_smoother_tb;
	import hros_pkg::*;

	localparam int HIST_N    = 10;
	localparam int N_RANDOM  = 2000;
	localparam int MAX_CYC   = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [15:0] raw_value;
	logic        value_bad;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] heart_rate;
	logic [1:0]  status;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	heart_rate_outlier_median_smoother dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .raw_value(raw_value), .value_bad(value_bad),
		.out_valid(out_valid), .out_stall(out_stall),
		.heart_rate(heart_rate), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of configuration and history
	logic        p_median;
	logic        p_int8;
	logic [15:0] p_scale;
	logic [7:0]  p_zero;
	logic [15:0] p_low, p_high, p_olim, p_fallback;
	logic [15:0] hist [HIST_N];
	int          wr_slot;
	int          n_stored;

	typedef struct packed {
		logic [15:0] rate;
		logic [1:0]  st;
	} hr_word_t;

	hr_word_t    rate_queue[$];
	int          mismatches;
	int          n_checked;
	int          n_sent;
	longint      cycles;
	int          st_seen[4];
	int          stall_left;

	// directed rows: fixed expectation only where obvious
	typedef struct {
		logic        c;
		logic [15:0] raw;
		logic        bad;
		logic        fixed;
		logic [15:0] rate;
		logic [1:0]  st;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles > MAX_CYC);
		$display("Timeout after %0d cycles", cycles);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [15:0] filter_out();
		logic [15:0] t [HIST_N];
		logic [15:0] x;
		logic [31:0] s;
		int          i, j;
		s = 0;
		if (n_stored == 0) return 16'd0;
		for (i = 0; i < n_stored; i++) s += hist[i];
		if (!p_median) return 16'(s / n_stored);
		for (i = 0; i < HIST_N; i++) t[i] = hist[i];
		for (i = 1; i < n_stored; i++) begin
			x = t[i];
			j = i;
			while (j > 0 && t[j-1] > x) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = x;
		end
		if (n_stored % 2 == 0)
			return 16'((32'(t[n_stored/2-1]) + 32'(t[n_stored/2])) / 2);
		return t[n_stored/2];
	endfunction

	// model one accepted word and return its expected result
	function automatic hr_word_t smooth_word(logic c, logic [15:0] raw, logic bad);
		hr_word_t    r;
		longint      v, d, p, dev, sum;
		int          i;
		if (c) begin
			for (i = 0; i < HIST_N; i++) hist[i] = 16'd0;
			wr_slot  = 0;
			n_stored = 0;
			r.rate   = p_fallback;
			r.st     = ST_CLEARED;
			return r;
		end
		if (p_int8) begin
			d = longint'($signed(raw[7:0])) - longint'($signed(p_zero));
			p = d * longint'(p_scale);
			v = (p >= 0) ? p / 16 : -((-p + 15) / 16);
		end else begin
			v = longint'($signed(raw));
		end
		if (bad || v < longint'(p_low) || v > longint'(p_high)) begin
			r.rate = (n_stored > 0) ? hist[(wr_slot + HIST_N - 1) % HIST_N] : p_fallback;
			r.st   = ST_INVALID;
			return r;
		end
		sum = 0;
		for (i = 0; i < n_stored; i++) sum += hist[i];
		dev = v * n_stored - sum;
		if (dev < 0) dev = -dev;
		if (n_stored > 0 && dev > longint'(p_olim) * n_stored) begin
			r.st = ST_OUTLIER;
		end else begin
			hist[wr_slot] = 16'(v);
			wr_slot = (wr_slot + 1) % HIST_N;
			if (n_stored < HIST_N) n_stored++;
			r.st = ST_ACCEPT;
		end
		r.rate = filter_out();
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_FILTER_MODE: p_median   = val[0];
			REG_INT8:        p_int8     = val[0];
			REG_SCALE:       p_scale    = val;
			REG_ZERO_POINT:  p_zero     = val[7:0];
			REG_LOW_LIMIT:   p_low      = val;
			REG_HIGH_LIMIT:  p_high     = val;
			REG_OUT_LIMIT:   p_olim     = val;
			REG_FALLBACK:    p_fallback = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// drive one word; expectation pushed as it is accepted
	task automatic send_word(logic c, logic [15:0] raw, logic bad);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		raw_value <= raw;
		value_bad <= bad;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		rate_queue.push_back(smooth_word(c, raw, bad));
		n_sent++;
	endtask

	// drain and then wait out a possibly busy block before a register write
	task automatic settle();
		in_valid <= 1'b0;
		while (rate_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// result side: stall runs of random length, compare against oldest expectation
	always @(posedge clk) begin
		hr_word_t e;
		if (out_valid && !out_stall) begin
			if (rate_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word: rate %h status %0d", heart_rate, status);
			end else begin
				e = rate_queue.pop_front();
				n_checked++;
				st_seen[status]++;
				if (heart_rate !== e.rate || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected rate %h status %0d, got %h %0d",
							e.rate, e.st, heart_rate, status);
				end
			end
		end
		if (arst_n) begin
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = ($urandom_range(0, 99) < 40) ? gap_len() : 0;
			end
		end
	end

	// a fixed expectation is also checked against the predictor's view
	task automatic run_row(row_t r);
		hr_word_t e;
		send_word(r.c, r.raw, r.bad);
		e = rate_queue[$];
		if (r.fixed && (e.rate !== r.rate || e.st !== r.st)) begin
			mismatches++;
			$display("Directed row: predictor %h/%0d, table %h/%0d",
				e.rate, e.st, r.rate, r.st);
		end
	endtask

	// random word: mostly in-range samples near a drifting rate
	task automatic random_word(int centre);
		int          k;
		logic [15:0] raw;
		k = $urandom_range(0, 99);
		if (k < 3) begin
			send_word(1'b1, 16'($urandom), 1'($urandom));
		end else if (k < 10) begin
			send_word(1'b0, 16'($urandom), 1'b1);
		end else if (k < 20 || p_int8) begin
			send_word(1'b0, 16'($urandom), 1'b0);
		end else begin
			raw = 16'(centre + $urandom_range(0, 8191) - 4096);
			send_word(1'b0, raw, 1'b0);
		end
	endtask

	initial begin
		row_t rows[$];
		int   i, phase, centre;
		arst_n = 1'b0; in_valid = 1'b0; cmd = 1'b0; raw_value = '0;
		value_bad = 1'b0; out_stall = 1'b0; cfg_we = 1'b0; cfg_index = '0;
		cfg_data = '0; cycles = 0; mismatches = 0; n_checked = 0; n_sent = 0;
		stall_left = 0;
		p_median = 1'b1; p_int8 = 1'b0; p_scale = 16'd4819; p_zero = 8'd0;
		p_low = 16'd7680; p_high = 16'd46080; p_olim = 16'd5120;
		p_fallback = 16'd19200; wr_slot = 0; n_stored = 0;
		for (i = 0; i < HIST_N; i++) hist[i] = 16'd0;
		for (i = 0; i < 4; i++) st_seen[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: empty history answers with the fallback rate
		rows.push_back('{1'b0, 16'h8000, 1'b0, 1'b1, 16'd19200, ST_INVALID});
		rows.push_back('{1'b0, 16'hFFFF, 1'b0, 1'b1, 16'd19200, ST_INVALID}); // negative
		rows.push_back('{1'b0, 16'd19200, 1'b1, 1'b1, 16'd19200, ST_INVALID});
		rows.push_back('{1'b0, 16'd7680, 1'b0, 1'b1, 16'd7680, ST_ACCEPT});   // low edge
		rows.push_back('{1'b0, 16'd7679, 1'b0, 1'b1, 16'd7680, ST_INVALID});  // just below
		rows.push_back('{1'b0, 16'd46081, 1'b0, 1'b1, 16'd7680, ST_INVALID});
		rows.push_back('{1'b0, 16'd30000, 1'b0, 1'b1, 16'd7680, ST_OUTLIER}); // far off mean
		rows.push_back('{1'b0, 16'd12800, 1'b0, 1'b1, 16'd10240, ST_ACCEPT}); // even median
		rows.push_back('{1'b0, 16'd12000, 1'b0, 1'b0, 16'd0, ST_ACCEPT});
		for (i = 0; i < 9; i++)
			rows.push_back('{1'b0, 16'(11000 + 300 * i), 1'b0, 1'b0, 16'd0, ST_ACCEPT});
		rows.push_back('{1'b0, 16'd0, 1'b1, 1'b0, 16'd0, ST_INVALID});     // last stored
		rows.push_back('{1'b1, 16'hFFFF, 1'b1, 1'b1, 16'd19200, ST_CLEARED});
		rows.push_back('{1'b0, 16'd0, 1'b0, 1'b1, 16'd19200, ST_INVALID});
		foreach (rows[i]) run_row(rows[i]);
		settle();

		// mean mode, int8 extremes
		write_reg(REG_FILTER_MODE, 16'd0);
		write_reg(REG_INT8, 16'd1);
		write_reg(REG_ZERO_POINT, 16'h0080);
		send_word(1'b0, 16'h007F, 1'b0);
		send_word(1'b0, 16'h0080, 1'b0);
		send_word(1'b0, 16'h0000, 1'b0);
		settle();
		write_reg(REG_SCALE, 16'hFFFF);
		write_reg(REG_ZERO_POINT, 16'h007F);
		send_word(1'b0, 16'hFF80, 1'b0);
		send_word(1'b0, 16'h007F, 1'b0);
		settle();

		// random phases across settings, extremes included
		for (phase = 0; phase < 8; phase++) begin
			write_reg(REG_FILTER_MODE, 16'(phase % 2));
			write_reg(REG_INT8, 16'(phase == 3 || phase == 6));
			write_reg(REG_SCALE, (phase == 3) ? 16'd4819 : 16'($urandom));
			write_reg(REG_ZERO_POINT, 16'($urandom_range(0, 255)));
			write_reg(REG_LOW_LIMIT, (phase == 5) ? 16'hFFFF : ((phase == 2) ? 16'd0 :
				16'($urandom_range(0, 12000))));
			write_reg(REG_HIGH_LIMIT, (phase == 2) ? 16'hFFFF : ((phase == 5) ? 16'd0 :
				16'($urandom_range(30000, 65535))));
			write_reg(REG_OUT_LIMIT, (phase == 4) ? 16'd0 : ((phase == 7) ? 16'hFFFF :
				16'($urandom_range(500, 8000))));
			write_reg(REG_FALLBACK, (phase == 1) ? 16'hFFFF : ((phase == 0) ? 16'd0 :
				16'($urandom)));
			centre = $urandom_range(10000, 30000);
			for (i = 0; i < N_RANDOM / 8; i++) begin
				if (i % 50 == 0) centre = $urandom_range(10000, 30000);
				random_word(centre);
			end
			settle();
		end

		repeat (100) @(posedge clk);
		$display("Checked %0d of %0d words: %0d accepted, %0d invalid, %0d outlier, %0d cleared",
			n_checked, n_sent, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
		$display("Covered mean and median modes, int8 dequantization, limit extremes");
		if (mismatches == 0 && rate_queue.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, rate_queue.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
design/hros_pkg.sv
design/hros_cell.sv
design/heart_rate_outlier_median_smoother.sv
tb/heart_rate_outlier_median_smoother_tb.sv
